### rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table package
// Shared constants, status codes and the item type passed from front to back.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int MaxSenders = 8;
	localparam int RingDepth = 30;

	localparam logic [7:0] PacketBytes = 8'd16;
	localparam logic [31:0] MagicMark = 32'hDEADBEEF;
	localparam logic [13:0] FullScale = 14'd10000;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LENGTH = 2'd1;
	localparam logic [1:0] ST_MAGIC = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  slot;
		logic        fresh;
		logic [31:0] seq;
		logic [15:0] distance;
	} job_t;

endpackage

### rtl/core/sst_front.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table front end
// Checks each item, matches the sender over one table entry per cycle and
// registers new senders, then queues a job for the back end.
// ----------------------------------------------------------------------------
module sst_front #(
	parameter int MAX_SENDERS = sst_pkg::MaxSenders
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          packet_length,
	input  logic [31:0]         magic_word,
	input  logic [31:0]         sequence_number,
	input  logic [47:0]         sender_mac,
	input  logic [15:0]         distance,
	output logic                job_valid,
	input  logic                job_ready,
	output sst_pkg::job_t       job
);

	localparam int SW = $clog2(MAX_SENDERS + 1);
	localparam int IW = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_SCAN = 2'd1;
	localparam logic [1:0] F_OUT = 2'd2;

	logic [1:0]  state_q;
	logic [SW-1:0] used_q;
	logic [SW-1:0] idx_q;
	logic [47:0] addr_q [MAX_SENDERS];
	logic [47:0] mac_q;
	sst_pkg::job_t job_q;

	assign full = (state_q != F_IDLE);
	assign job_valid = (state_q == F_OUT);
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			used_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						idx_q <= '0;
						if (packet_length != sst_pkg::PacketBytes) begin
							state_q <= F_OUT;
						end else if (magic_word != sst_pkg::MagicMark) begin
							state_q <= F_OUT;
						end else begin
							state_q <= F_SCAN;
						end
					end
				end
				F_SCAN: begin
					if (idx_q == used_q) begin
						if (used_q != SW'(MAX_SENDERS)) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= F_OUT;
					end else if (addr_q[idx_q[IW-1:0]] == mac_q) begin
						state_q <= F_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				F_OUT: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			mac_q <= sender_mac;
			job_q.seq <= sequence_number;
			job_q.distance <= distance;
			job_q.slot <= '0;
			job_q.fresh <= 1'b0;
			if (packet_length != sst_pkg::PacketBytes) begin
				job_q.status <= sst_pkg::ST_LENGTH;
			end else if (magic_word != sst_pkg::MagicMark) begin
				job_q.status <= sst_pkg::ST_MAGIC;
			end else begin
				job_q.status <= sst_pkg::ST_OK;
			end
		end else if (state_q == F_SCAN) begin
			if (idx_q == used_q) begin
				if (used_q == SW'(MAX_SENDERS)) begin
					job_q.status <= sst_pkg::ST_FULL;
				end else begin
					addr_q[idx_q[IW-1:0]] <= mac_q;
					job_q.slot <= 7'(idx_q);
					job_q.fresh <= 1'b1;
				end
			end else if (addr_q[idx_q[IW-1:0]] == mac_q) begin
				job_q.slot <= 7'(idx_q);
			end
		end
	end

endmodule

### rtl/core/sst_queue.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sst_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sst_pkg::job_t in_job,
	output logic          out_valid,
	input  logic          out_ready,
	output sst_pkg::job_t out_job
);

	sst_pkg::job_t mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job = mem_q[rp_q];
	assign do_push = in_valid && in_ready;
	assign do_pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= in_job;
	end

endmodule

### rtl/core/sst_back.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table back end
// Computes the fill level with a serial divider, updates the sender's
// counters and ring, walks the ring for min, max and sum, and divides the sum.
// ----------------------------------------------------------------------------
module sst_back #(
	parameter int MAX_SENDERS = sst_pkg::MaxSenders,
	parameter int RING_DEPTH = sst_pkg::RingDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [14:0]         cfg_height,
	input  logic [13:0]         cfg_thresh,
	input  logic                job_valid,
	output logic                job_ready,
	input  sst_pkg::job_t       job,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          status,
	output logic [2:0]          entry_index,
	output logic                new_entry,
	output logic [31:0]         sequence_echo,
	output logic [13:0]         fill_level,
	output logic [13:0]         average_fill,
	output logic [13:0]         minimum_fill,
	output logic [13:0]         maximum_fill,
	output logic [31:0]         alert_total,
	output logic [31:0]         sender_readings,
	output logic [31:0]         all_readings,
	output logic [4:0]          ring_count
);

	localparam int IW = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
	localparam int PW = $clog2(RING_DEPTH + 1);
	localparam int RW = $clog2(RING_DEPTH);
	localparam int MD = MAX_SENDERS * RING_DEPTH;
	localparam int AW = $clog2(MD);
	localparam int SUMW = 14 + PW;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_FDIV = 3'd1;
	localparam logic [2:0] B_UPD = 3'd2;
	localparam logic [2:0] B_WALK = 3'd3;
	localparam logic [2:0] B_ADIV = 3'd4;
	localparam logic [2:0] B_OUT = 3'd5;

	logic [2:0]    state_q;
	logic [14:0]   height_q;
	logic [13:0]   thresh_q;

	logic [PW-1:0] wptr_q [MAX_SENDERS];
	logic          wrap_q [MAX_SENDERS];
	logic [31:0]   alert_q [MAX_SENDERS];
	logic [31:0]   reads_q [MAX_SENDERS];
	logic [31:0]   total_q;
	logic [13:0]   ring_mem [MD];
	logic [13:0]   rd_q;

	sst_pkg::job_t job_q;
	logic [IW-1:0] slot_q;
	logic [28:0]   rem_q;
	logic [28:0]   quo_q;
	logic [4:0]    bit_q;
	logic [PW-1:0] cnt_q;
	logic [PW-1:0] walk_q;
	logic          rdv_q;
	logic [SUMW-1:0] sum_q;
	logic [13:0]   lo_q;
	logic [13:0]   hi_q;
	logic [13:0]   fill_q;
	logic [31:0]   alert_r_q;
	logic [31:0]   reads_r_q;

	logic [14:0]   dclamp;
	logic [28:0]   num_fill;
	logic [29:0]   trial;
	logic [AW-1:0] base;
	logic [PW-1:0] nptr;
	logic [28:0]   divisor;

	assign dclamp = (job.distance[14:0] > height_q) ? height_q : job.distance[14:0];
	assign num_fill = 29'(height_q - dclamp) * 29'(sst_pkg::FullScale);
	assign base = AW'(slot_q) * AW'(RING_DEPTH);
	assign nptr = (wptr_q[slot_q] == PW'(RING_DEPTH - 1)) ? '0 : wptr_q[slot_q] + 1'b1;
	assign divisor = (state_q == B_FDIV) ? 29'(height_q) : 29'(cnt_q);
	assign trial = {rem_q, quo_q[28]} - {1'b0, divisor};

	assign job_ready = (state_q == B_IDLE);
	assign empty = (state_q != B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			height_q <= 15'd1000;
			thresh_q <= 14'd8000;
			total_q <= '0;
			for (int i = 0; i < MAX_SENDERS; i++) begin
				wptr_q[i] <= '0;
				wrap_q[i] <= 1'b0;
				alert_q[i] <= '0;
				reads_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				height_q <= cfg_height;
				thresh_q <= cfg_thresh;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						if (job.status != sst_pkg::ST_OK) begin
							state_q <= B_OUT;
						end else begin
							state_q <= B_FDIV;
						end
					end
				end
				B_FDIV: begin
					if (bit_q == 5'd0) state_q <= B_UPD;
				end
				B_UPD: begin
					if (job_q.fresh) begin
						alert_q[slot_q] <= {31'd0, fill_q >= thresh_q};
						reads_q[slot_q] <= 32'd1;
						wrap_q[slot_q] <= 1'b0;
						wptr_q[slot_q] <= PW'(1);
					end else begin
						alert_q[slot_q] <= alert_q[slot_q] + {31'd0, fill_q >= thresh_q};
						reads_q[slot_q] <= reads_q[slot_q] + 1'b1;
						wptr_q[slot_q] <= nptr;
						if (nptr == '0) wrap_q[slot_q] <= 1'b1;
					end
					total_q <= total_q + 1'b1;
					state_q <= B_WALK;
				end
				B_WALK: begin
					if (rdv_q && walk_q == cnt_q) state_q <= B_ADIV;
				end
				B_ADIV: begin
					if (bit_q == 5'd0) state_q <= B_OUT;
				end
				B_OUT: begin
					if (pop) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= ring_mem[base + AW'(walk_q[RW-1:0])];
		unique case (state_q)
			B_IDLE: begin
				job_q <= job;
				slot_q <= IW'(job.slot);
				rem_q <= '0;
				bit_q <= 5'd28;
				if (job.distance[15] || height_q == '0) begin
					quo_q <= '0;
				end else begin
					quo_q <= num_fill;
				end
			end
			B_FDIV: begin
				if (!trial[29]) begin
					rem_q <= trial[28:0];
				end else begin
					rem_q <= {rem_q[27:0], quo_q[28]};
				end
				quo_q <= {quo_q[27:0], !trial[29]};
				bit_q <= bit_q - 1'b1;
				if (bit_q == 5'd0) begin
					fill_q <= (height_q == '0) ? '0 : 14'({quo_q[27:0], !trial[29]});
				end
			end
			B_UPD: begin
				ring_mem[base + AW'(job_q.fresh ? '0 : wptr_q[slot_q][RW-1:0])] <= fill_q;
				alert_r_q <= job_q.fresh ? {31'd0, fill_q >= thresh_q}
					: alert_q[slot_q] + {31'd0, fill_q >= thresh_q};
				reads_r_q <= job_q.fresh ? 32'd1 : reads_q[slot_q] + 1'b1;
				if (job_q.fresh) cnt_q <= PW'(1);
				else if (wrap_q[slot_q] || nptr == '0) cnt_q <= PW'(RING_DEPTH);
				else cnt_q <= nptr;
				walk_q <= '0;
				rdv_q <= 1'b0;
				sum_q <= '0;
				lo_q <= sst_pkg::FullScale;
				hi_q <= '0;
			end
			B_WALK: begin
				if (rdv_q) begin
					sum_q <= sum_q + SUMW'(rd_q);
					if (rd_q < lo_q) lo_q <= rd_q;
					if (rd_q > hi_q) hi_q <= rd_q;
				end
				if (walk_q != cnt_q) begin
					walk_q <= walk_q + 1'b1;
					rdv_q <= 1'b1;
				end
				if (rdv_q && walk_q == cnt_q) begin
					rem_q <= '0;
					quo_q <= 29'(sum_q + SUMW'(rd_q));
					bit_q <= 5'd28;
				end
			end
			B_ADIV: begin
				if (!trial[29]) begin
					rem_q <= trial[28:0];
				end else begin
					rem_q <= {rem_q[27:0], quo_q[28]};
				end
				quo_q <= {quo_q[27:0], !trial[29]};
				bit_q <= bit_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	logic ok;
	assign ok = (job_q.status == sst_pkg::ST_OK);
	assign status = job_q.status;
	assign entry_index = ok ? 3'(slot_q) : '0;
	assign new_entry = ok & job_q.fresh;
	assign sequence_echo = ok ? job_q.seq : '0;
	assign fill_level = ok ? fill_q : '0;
	assign average_fill = ok ? quo_q[13:0] : '0;
	assign minimum_fill = ok ? lo_q : '0;
	assign maximum_fill = ok ? hi_q : '0;
	assign alert_total = ok ? alert_r_q : '0;
	assign sender_readings = ok ? reads_r_q : '0;
	assign all_readings = ok ? total_q : '0;
	assign ring_count = ok ? 5'(cnt_q) : '0;

endmodule

### rtl/core/sensor_sender_stats_table_unit.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table
// Per-sender fill level table with windowed minimum, maximum and average.
// ----------------------------------------------------------------------------
// Items enter through push/full and results leave through empty/pop, one
// result per item, in order. The user must write configuration through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this. The front end checks an item and scans
// the sender table one entry per cycle. A two-entry queue passes the job
// to the back end, which runs the fill division, the update, the ring
// walk and the average division in turn; a rejected item skips them.
// The back end sets the sustained rate.
// Reset clears the table, the counters and the registers to their defaults.
// While pop stays low the result holds; the front end and the queue can
// still hold three more items, after which full stays high.
// ----------------------------------------------------------------------------
module sensor_sender_stats_table_unit #(
	parameter int MAX_SENDERS = sst_pkg::MaxSenders,
	parameter int RING_DEPTH = sst_pkg::RingDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  packet_length,
	input  logic [31:0] magic_word,
	input  logic [31:0] sequence_number,
	input  logic [47:0] sender_mac,
	input  logic [15:0] distance,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [2:0]  entry_index,
	output logic        new_entry,
	output logic [31:0] sequence_echo,
	output logic [13:0] fill_level,
	output logic [13:0] average_fill,
	output logic [13:0] minimum_fill,
	output logic [13:0] maximum_fill,
	output logic [31:0] alert_total,
	output logic [31:0] sender_readings,
	output logic [31:0] all_readings,
	output logic [4:0]  ring_count
);

	logic          fj_valid;
	logic          fj_ready;
	sst_pkg::job_t fj;
	logic          bj_valid;
	logic          bj_ready;
	sst_pkg::job_t bj;
	logic [14:0]   height_q;
	logic [13:0]   thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 15'd1000;
			thresh_q <= 14'd8000;
		end else if (cfg_we) begin
			if (cfg_index == sst_pkg::REG_HEIGHT) height_q <= cfg_data;
			else thresh_q <= cfg_data[13:0];
		end
	end

	sst_front #(.MAX_SENDERS(MAX_SENDERS)) u_front (
		.clk, .arst_n, .push, .full, .packet_length, .magic_word,
		.sequence_number, .sender_mac, .distance,
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	sst_queue u_queue (
		.clk, .arst_n, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
		.out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
	);

	sst_back #(.MAX_SENDERS(MAX_SENDERS), .RING_DEPTH(RING_DEPTH)) u_back (
		.clk, .arst_n, .cfg_we(1'b1), .cfg_height(height_q), .cfg_thresh(thresh_q),
		.job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.empty, .pop, .status, .entry_index, .new_entry, .sequence_echo,
		.fill_level, .average_fill, .minimum_fill, .maximum_fill,
		.alert_total, .sender_readings, .all_readings, .ring_count
	);

endmodule

### rtl/core/sst_checker.sv
// ----------------------------------------------------------------------------
// Sensor sender statistics table checker
// Port-level properties of the table, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [2:0]  entry_index,
	input logic        new_entry,
	input logic [31:0] sequence_echo,
	input logic [4:0]  ring_count,
	input logic [31:0] sender_readings
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(sequence_echo))
		else $error("result changed while stalled");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != sst_pkg::ST_OK |-> entry_index == '0 && !new_entry)
		else $error("rejected item carries a slot");

	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && new_entry |-> ring_count == 5'd1 && sender_readings == 32'd1)
		else $error("new sender not cleared");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == sst_pkg::ST_OK |-> ring_count != '0)
		else $error("accepted item with empty ring");

endmodule

bind sensor_sender_stats_table_unit sst_checker u_sst_checker (
	.clk, .arst_n, .empty, .pop, .status, .entry_index, .new_entry,
	.sequence_echo, .ring_count, .sender_readings
);
